@@ src/prtm_pkg.sv @@
// Shared types and codes for the posted receive tag matcher.
`timescale 1ns / 1ps
package prtm_pkg;
	localparam logic [1:0] ST_POSTED  = 2'd0;
	localparam logic [1:0] ST_DROPPED = 2'd1;
	localparam logic [1:0] ST_MATCHED = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	localparam logic CFG_WILD_TAG  = 1'b0;
	localparam logic CFG_WILD_RANK = 1'b1;

	// key fields of one posted entry, without the request id
	typedef struct packed {
		logic [63:0] tag;
		logic [63:0] ign;
		logic [23:0] rank;
		logic [15:0] group;
		logic [30:0] count;
		logic [7:0]  size;
	} key_t;

	// shift controls broadcast to every cell
	typedef struct packed {
		logic ins;    // insert at front, all entries move back
		logic cmp;    // latch compare results
		logic rem;    // close the gap at the first hit
	} ctl_t;
endpackage

@@ src/prtm_cell.sv @@
// One queue slot: holds an entry, compares it, shifts to its neighbors.
`timescale 1ns / 1ps
module prtm_cell #(
	parameter int REQ_ID_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  prtm_pkg::ctl_t         ctl,
	input  logic [63:0]            wild_tag,
	input  logic [23:0]            wild_rank,
	input  prtm_pkg::key_t         probe,
	input  prtm_pkg::key_t         prev_key,
	input  logic [REQ_ID_BITS-1:0] prev_req,
	input  logic                   prev_valid,
	input  prtm_pkg::key_t         next_key,
	input  logic [REQ_ID_BITS-1:0] next_req,
	input  logic                   next_valid,
	input  logic                   hit_before,  // some cell in front was a hit
	output prtm_pkg::key_t         key_q,
	output logic [REQ_ID_BITS-1:0] req_q,
	output logic                   valid_q,
	output logic                   hit_q
);
	logic [63:0] keep;
	logic        match;

	// parallel compare against the arriving header
	assign keep  = ~key_q.ign;
	assign match = valid_q
		&& ((key_q.tag == wild_tag) || ((key_q.tag & keep) == (probe.tag & keep)))
		&& ((key_q.rank == wild_rank) || (key_q.rank == probe.rank))
		&& (key_q.group == probe.group) && (key_q.count == probe.count)
		&& (key_q.size == probe.size);

	// valid bit and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.cmp) hit_q <= match;
			if (ctl.ins) valid_q <= prev_valid;
			else if (ctl.rem && (hit_q || hit_before)) valid_q <= next_valid;
		end
	end

	// payload moves back on insert, forward from the hit on remove
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			key_q <= prev_key;
			req_q <= prev_req;
		end else if (ctl.rem && (hit_q || hit_before)) begin
			key_q <= next_key;
			req_q <= next_req;
		end
	end
endmodule

@@ src/posted_receive_tag_matcher.sv @@
// Top level: chain of queue cells, hit selection and result register.
`timescale 1ns / 1ps
// Posted receive queue as a row of QUEUE_DEPTH cells, newest at the front.
// A post inserts at the front as every cell shifts back in parallel; an
// arrive has the accepting cycle, where every cell compares the header at
// once, and then a step where the first hit is chosen by a priority scan and
// the cells behind it shift forward. The result sits in an output register,
// and a new item is taken in the cycle that the previous result is delivered.
// For an arrive, the count of entries examined is the position of the first
// hit plus one, or occupancy; for a post it is zero.
module posted_receive_tag_matcher #(
	parameter int QUEUE_DEPTH = 64,
	parameter int REQ_ID_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [63:0] tag,
	input  logic [63:0] ignore_mask,
	input  logic [23:0] rank,
	input  logic [15:0] group,
	input  logic [30:0] elem_count,
	input  logic [7:0]  elem_size,
	input  logic [15:0] req_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] match_req_id,
	output logic [6:0]  entries_examined,
	output logic [6:0]  occupancy,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [63:0]            wild_tag_q;
	logic [23:0]            wild_rank_q;
	logic [CW-1:0]          fill_q;
	logic                   busy_q;   // compare latched, removal pending
	prtm_pkg::ctl_t         ctl;
	prtm_pkg::key_t         new_key;
	prtm_pkg::key_t         key_w  [QUEUE_DEPTH];
	logic [REQ_ID_BITS-1:0] req_w  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_w, hit_w, before_w;
	logic                   take, full, any_hit;
	logic [IW-1:0]          hit_idx;
	logic [REQ_ID_BITS-1:0] hit_req;

	assign in_stall = busy_q || (out_valid && out_stall);
	assign take     = in_valid && !in_stall;
	assign full     = (fill_q == CW'(QUEUE_DEPTH));
	assign ctl.ins  = take && !action && !full;
	assign ctl.cmp  = take && action;
	assign ctl.rem  = busy_q;

	assign new_key = '{tag: tag, ign: ignore_mask, rank: rank, group: group,
		count: elem_count, size: elem_size};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wild_tag_q  <= '1;
			wild_rank_q <= '1;
		end else if (cfg_we) begin
			if (cfg_index == prtm_pkg::CFG_WILD_TAG) wild_tag_q <= cfg_data;
			else wild_rank_q <= cfg_data[23:0];
		end
	end

	// row of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		prtm_pkg::key_t         pk, nk;
		logic [REQ_ID_BITS-1:0] pr, nr;
		logic                   pv, nv;
		if (i == 0) begin : g_front
			assign pk = new_key;
			assign pr = REQ_ID_BITS'(req_id);
			assign pv = 1'b1;
			assign before_w[i] = 1'b0;
		end else begin : g_mid
			assign pk = key_w[i-1];
			assign pr = req_w[i-1];
			assign pv = valid_w[i-1];
			assign before_w[i] = before_w[i-1] | hit_w[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_back
			assign nk = key_w[i];
			assign nr = req_w[i];
			assign nv = 1'b0;
		end else begin : g_inner
			assign nk = key_w[i+1];
			assign nr = req_w[i+1];
			assign nv = valid_w[i+1];
		end
		prtm_cell #(.REQ_ID_BITS(REQ_ID_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.wild_tag(wild_tag_q), .wild_rank(wild_rank_q), .probe(new_key),
			.prev_key(pk), .prev_req(pr), .prev_valid(pv),
			.next_key(nk), .next_req(nr), .next_valid(nv),
			.hit_before(before_w[i]),
			.key_q(key_w[i]), .req_q(req_w[i]), .valid_q(valid_w[i]),
			.hit_q(hit_w[i])
		);
	end

	// first hit from the front
	always_comb begin
		hit_idx = '0;
		hit_req = '0;
		for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
			if (hit_w[k]) begin
				hit_idx = IW'(k);
				hit_req = req_w[k];
			end
		end
	end
	assign any_hit = |hit_w;

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q           <= 1'b0;
			fill_q           <= '0;
			out_valid        <= 1'b0;
			status           <= prtm_pkg::ST_POSTED;
			match_req_id     <= '0;
			entries_examined <= '0;
			occupancy        <= '0;
		end else begin
			if ((take && !action) || busy_q) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			busy_q <= ctl.cmp;
			if (take && !action) begin
				status           <= full ? prtm_pkg::ST_DROPPED : prtm_pkg::ST_POSTED;
				match_req_id     <= '0;
				entries_examined <= '0;
				occupancy        <= 7'(fill_q + CW'(!full));
				if (!full) fill_q <= fill_q + 1'b1;
			end
			if (busy_q) begin
				match_req_id <= 16'(hit_req);
				if (any_hit) begin
					status           <= prtm_pkg::ST_MATCHED;
					entries_examined <= 7'(hit_idx) + 7'd1;
					occupancy        <= 7'(fill_q - 1'b1);
					fill_q           <= fill_q - 1'b1;
				end else begin
					status           <= prtm_pkg::ST_NOMATCH;
					entries_examined <= 7'(fill_q);
					occupancy        <= 7'(fill_q);
				end
			end
		end
	end
endmodule
